@@ src/lfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lfpr_pkg: shared definitions for the length-framed packet receiver
// Field widths, phase, status and kind codes, and the item types passed
// between the receiver's pipeline stages.
// ----------------------------------------------------------------------------
package lfpr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PhaseW  = 3;

  // Receiver phases
  localparam logic [PhaseW-1:0] PhWait  = 3'd0;
  localparam logic [PhaseW-1:0] PhLenHi = 3'd1;
  localparam logic [PhaseW-1:0] PhLenLo = 3'd2;
  localparam logic [PhaseW-1:0] PhData  = 3'd3;
  localparam logic [PhaseW-1:0] PhSum   = 3'd4;
  localparam logic [PhaseW-1:0] PhEnd   = 3'd5;

  // Input command codes
  localparam logic CmdByte    = 1'b0;
  localparam logic CmdTimeout = 1'b1;

  // Result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  // Frame status codes
  localparam logic [StatusW-1:0] StGood   = 2'd0;
  localparam logic [StatusW-1:0] StBadSum = 2'd1;
  localparam logic [StatusW-1:0] StFail   = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [ByteW-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [ByteW-1:0]   payload_byte;
    logic               last_payload;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   response;
    logic [LenW-1:0]    frame_length;
  } out_item_t;

  // Handshake state of a pipeline stage as seen by its neighbours
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

endpackage

@@ src/lfpr_if.sv @@
// ----------------------------------------------------------------------------
// lfpr_if: channel interfaces of the packet receiver
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
interface lfpr_in_if import lfpr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface lfpr_out_if import lfpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ByteW-1:0]   payload_byte;
  logic               last_payload;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   response;
  logic [LenW-1:0]    frame_length;

  modport source (output valid, output kind, output payload_byte, output last_payload,
                  output status, output response, output frame_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input last_payload,
                  input status, input response, input frame_length, output ready);
endinterface

@@ src/lfpr_in_stage.sv @@
// ----------------------------------------------------------------------------
// lfpr_in_stage: input register
// Captures one received transaction and holds it until the deframer takes it.
// ----------------------------------------------------------------------------
module lfpr_in_stage import lfpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfpr_in_if.sink     item_i,
  input  logic        advance_i,
  output logic        valid_o,
  output in_item_t    item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign item_i.ready = !valid_q || advance_i;
  assign load         = item_i.valid && item_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.cmd     <= item_i.cmd;
      item_q.rx_byte <= item_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/lfpr_deframer.sv @@
// ----------------------------------------------------------------------------
// lfpr_deframer: frame phase machine
// Tracks the frame phase, length, payload count, running sum and response
// code, and forms at most one result for each byte it takes.
// ----------------------------------------------------------------------------
module lfpr_deframer import lfpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stage_ctrl_t ctrl_i,
  input  in_item_t    item_i,
  output logic        emit_o,
  output out_item_t   result_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [LenW-1:0]   remaining_q, remaining_d;
  logic [LenW-1:0]   length_q, length_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  resp_q, resp_d;
  logic              seen_q, seen_d;
  logic [LenW-1:0]   rem_dec;
  logic [ByteW-1:0]  sum_add;
  logic              emit;
  out_item_t         result;

  assign rem_dec = remaining_q - LenW'(1);
  assign sum_add = sum_q + item_i.rx_byte;

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    length_d    = length_q;
    sum_d       = sum_q;
    resp_d      = resp_q;
    seen_d      = seen_q;
    emit        = 1'b0;
    result      = '0;

    if (item_i.cmd == CmdTimeout) begin
      // A timeout aborts whatever is in progress, even when idle.
      emit                = 1'b1;
      result.kind         = KindStatus;
      result.status       = StFail;
      result.response     = resp_q;
      result.frame_length = length_q;
      phase_d     = PhWait;
      remaining_d = '0;
      length_d    = '0;
      sum_d       = '0;
      resp_d      = '0;
      seen_d      = 1'b0;
    end else begin
      case (phase_q)
        PhLenHi: begin
          length_d = {item_i.rx_byte, {ByteW{1'b0}}};
          sum_d    = sum_add;
          phase_d  = PhLenLo;
        end
        PhLenLo: begin
          length_d    = {length_q[LenW-1:ByteW], item_i.rx_byte};
          remaining_d = {length_q[LenW-1:ByteW], item_i.rx_byte};
          sum_d       = sum_add;
          phase_d     = (remaining_d != '0) ? PhData : PhSum;
        end
        PhData: begin
          if (!seen_q) begin
            resp_d = item_i.rx_byte;
            seen_d = 1'b1;
          end
          sum_d       = sum_add;
          remaining_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PhSum;
          end
          emit                = 1'b1;
          result.kind         = KindPayload;
          result.payload_byte = item_i.rx_byte;
          result.last_payload = (rem_dec == '0);
          result.status       = StGood;
          result.frame_length = length_q;
        end
        PhSum: begin
          // With an empty payload the sum byte doubles as the response code.
          if (!seen_q) begin
            resp_d = item_i.rx_byte;
            seen_d = 1'b1;
          end
          sum_d   = sum_add;
          phase_d = PhEnd;
        end
        PhEnd: begin
          emit                = 1'b1;
          result.kind         = KindStatus;
          result.status       = (sum_q == '0) ? StGood : StBadSum;
          result.response     = resp_q;
          result.frame_length = length_q;
          phase_d     = PhWait;
          remaining_d = '0;
          length_d    = '0;
          sum_d       = '0;
          resp_d      = '0;
          seen_d      = 1'b0;
        end
        default: begin
          // Waiting, or a code with no meaning: any byte opens a frame.
          phase_d     = PhLenHi;
          remaining_d = '0;
          length_d    = '0;
          sum_d       = '0;
          resp_d      = '0;
          seen_d      = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhWait;
      remaining_q <= '0;
      length_q    <= '0;
      sum_q       <= '0;
      resp_q      <= '0;
      seen_q      <= 1'b0;
    end else if (ctrl_i.advance) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      length_q    <= length_d;
      sum_q       <= sum_d;
      resp_q      <= resp_d;
      seen_q      <= seen_d;
    end
  end

  assign emit_o   = ctrl_i.valid && emit;
  assign result_o = result;

endmodule

@@ src/lfpr_out_stage.sv @@
// ----------------------------------------------------------------------------
// lfpr_out_stage: result register
// Holds one result item until the sink accepts it, and reports whether the
// deframer may move on this cycle.
// ----------------------------------------------------------------------------
module lfpr_out_stage import lfpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stage_ctrl_t ctrl_i,
  input  logic        emit_i,
  input  out_item_t   result_i,
  output logic        space_o,
  lfpr_out_if.source  result_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;
  logic      load;

  // The register may be refilled in the same cycle in which its content leaves.
  assign space_o = !valid_q || result_o.ready;
  assign load    = ctrl_i.advance && emit_i;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= result_i;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.kind         = item_q.kind;
  assign result_o.payload_byte = item_q.payload_byte;
  assign result_o.last_payload = item_q.last_payload;
  assign result_o.status       = item_q.status;
  assign result_o.response     = item_q.response;
  assign result_o.frame_length = item_q.frame_length;

endmodule

@@ src/length_framed_packet_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// length_framed_packet_receiver_unit: length-framed packet receiver
// Takes a serial answer apart byte by byte: passes payload bytes on, marks
// the last one, and closes each frame with a status carrying the response
// code and the result of the 8-bit zero-sum check.
//
//   Channel   Direction  Carries                                       Rule
//   item_i    in         cmd, rx_byte                                  valid/ready
//   result_o  out        kind, payload_byte, last_payload, status,     valid/ready
//                        response, frame_length
//
// One byte is taken every cycle while the result side keeps up; the
// phase, counter and sum update in the single stage between the input
// register and the result register, so a result follows its byte through
// both registers. Reset returns the block to waiting for a start
// byte with empty registers. A stalled result holds the deframer, and the
// input register then fills and drops ready.
// ----------------------------------------------------------------------------
module length_framed_packet_receiver_unit import lfpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lfpr_in_if.sink    item_i,
  lfpr_out_if.source result_o
);

  logic        in_valid;
  in_item_t    in_item;
  logic        out_space;
  logic        emit;
  out_item_t   result;
  stage_ctrl_t ctrl;

  assign ctrl.valid   = in_valid;
  assign ctrl.advance = in_valid && out_space;

  lfpr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .advance_i (ctrl.advance),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  lfpr_deframer u_deframer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .item_i   (in_item),
    .emit_o   (emit),
    .result_o (result)
  );

  lfpr_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .emit_i   (emit),
    .result_i (result),
    .space_o  (out_space),
    .result_o (result_o)
  );

endmodule

@@ tb/lfpr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpr_checker: result checker for the length-framed packet receiver
// Watches both channels, deframes every accepted input transaction with its
// own copy of the receiver state, and compares each accepted result with the
// oldest expected one, field by field.
// ----------------------------------------------------------------------------
module lfpr_checker import lfpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lfpr_in_if   in_ch,
  lfpr_out_if  out_ch,
  output int   fail_count_o,
  output int   pending_o
);

  logic [PhaseW-1:0] phase_q;
  logic [LenW-1:0]   left_q;
  logic [LenW-1:0]   length_q;
  logic [ByteW-1:0]  sum_q;
  logic [ByteW-1:0]  resp_q;
  logic              resp_taken_q;

  out_item_t due_results[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic void clear_frame();
    phase_q      = PhWait;
    left_q       = '0;
    length_q     = '0;
    sum_q        = '0;
    resp_q       = '0;
    resp_taken_q = 1'b0;
  endfunction

  function automatic void note_response(input logic [ByteW-1:0] b);
    if (!resp_taken_q) begin
      resp_q       = b;
      resp_taken_q = 1'b1;
    end
  endfunction

  // Advances the frame state by one received byte or timeout and queues the
  // result that it produces, if any.
  function automatic void deframe_byte(input logic cmd, input logic [ByteW-1:0] b);
    out_item_t res;
    res = '0;
    res.frame_length = length_q;
    if (cmd == CmdTimeout) begin
      res.kind     = KindStatus;
      res.status   = StFail;
      res.response = resp_q;
      due_results.push_back(res);
      clear_frame();
      return;
    end
    case (phase_q)
      PhLenHi: begin
        length_q = {b, 8'h00};
        sum_q    = sum_q + b;
        phase_q  = PhLenLo;
      end
      PhLenLo: begin
        length_q[7:0] = b;
        sum_q         = sum_q + b;
        left_q        = length_q;
        phase_q       = (length_q != 0) ? PhData : PhSum;
      end
      PhData: begin
        note_response(b);
        sum_q  = sum_q + b;
        left_q = left_q - 1'b1;
        res.kind         = KindPayload;
        res.payload_byte = b;
        res.last_payload = (left_q == 0);
        res.frame_length = length_q;
        if (left_q == 0) begin
          phase_q = PhSum;
        end
        due_results.push_back(res);
      end
      PhSum: begin
        note_response(b);
        sum_q   = sum_q + b;
        phase_q = PhEnd;
      end
      PhEnd: begin
        res.kind     = KindStatus;
        res.status   = (sum_q == 0) ? StGood : StBadSum;
        res.response = resp_q;
        due_results.push_back(res);
        clear_frame();
      end
      default: begin
        // Any byte opens a frame, including one in an undefined phase.
        clear_frame();
        phase_q = PhLenHi;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_frame();
      due_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transaction with no result expected");
        end else begin
          want = due_results.pop_front();
          check_field("kind", out_ch.kind, want.kind);
          check_field("payload_byte", out_ch.payload_byte, want.payload_byte);
          check_field("last_payload", out_ch.last_payload, want.last_payload);
          check_field("status", out_ch.status, want.status);
          check_field("response", out_ch.response, want.response);
          check_field("frame_length", out_ch.frame_length, want.frame_length);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.cmd, in_ch.rx_byte);
      end
      pending_o = due_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the length-framed packet receiver
// Drives directed frames covering the field extremes, an idle timeout and
// one mid-payload, then random well-formed, corrupted and truncated frames
// with random gaps and result stalls; the checker predicts and compares all.
// ----------------------------------------------------------------------------
module tb;
  import lfpr_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemTarget = 1950;
  localparam int unsigned DrainEvery = 250;

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   items_sent;
  int   fail_count;
  int   pending;
  int unsigned cycles;

  lfpr_in_if  item_ch ();
  lfpr_out_if result_ch ();

  length_framed_packet_receiver_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .result_o(result_ch)
  );

  lfpr_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (item_ch),
    .out_ch      (result_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the
  // transaction has been accepted.
  task automatic send_item(input logic cmd, input logic [ByteW-1:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_ch.valid   <= 1'b1;
    item_ch.cmd     <= cmd;
    item_ch.rx_byte <= b;
    do @(posedge clk_i); while (!item_ch.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Always lets at least one falling edge pass, so the caller never drives
  // valid twice in the same time step.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Sends one frame of len payload bytes. With abort_at at or above zero,
  // a timeout replaces the byte at that position and ends the frame.
  task automatic send_frame(input int unsigned len, input bit bad_sum, input int abort_at);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int unsigned      idx;
    sum = '0;
    for (idx = 0; idx < len + 5; idx++) begin
      if (idx == abort_at) begin
        send_item(CmdTimeout, ByteW'($urandom_range(0, 255)));
        return;
      end
      if (idx == 1) begin
        b = len[15:8];
      end else if (idx == 2) begin
        b = len[7:0];
      end else if (idx == len + 3) begin
        b = -sum;
        if (bad_sum) begin
          b = b + ByteW'($urandom_range(1, 255));
        end
      end else begin
        b = ByteW'($urandom_range(0, 255));
      end
      if (idx >= 1 && idx < len + 3) begin
        sum = sum + b;
      end
      send_item(CmdByte, b);
    end
  endtask

  // Result side: a random stall before each result, none while calm.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned len;
    int          abort_at;
    int unsigned pick;
    int          next_drain;
    bit          bad_sum;
    rst_ni          = 1'b0;
    calm            = 1'b0;
    items_sent      = 0;
    cycles          = 0;
    item_ch.valid   = 1'b0;
    item_ch.cmd     = CmdByte;
    item_ch.rx_byte = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Timeout with no frame in progress.
    send_item(CmdTimeout, 8'hA5);
    // Empty frame: the sum byte doubles as the response code.
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'hFF);
    // One payload byte with a wrong sum byte.
    send_item(CmdByte, 8'hFF);
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'h01);
    send_item(CmdByte, 8'hFF);
    send_item(CmdByte, 8'h5A);
    send_item(CmdByte, 8'h00);
    // Two payload bytes at the extremes, good sum.
    send_item(CmdByte, 8'h5A);
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'h02);
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'hFF);
    send_item(CmdByte, 8'hFF);
    send_item(CmdByte, 8'hC3);
    // Longest length, cut short by a timeout in the payload.
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'hFF);
    send_item(CmdByte, 8'hFF);
    send_item(CmdByte, 8'h12);
    send_item(CmdByte, 8'h34);
    send_item(CmdTimeout, 8'h00);

    drain_results();
    next_drain = items_sent + DrainEvery;

    while (items_sent < ItemTarget) begin
      calm     = ($urandom_range(0, 5) == 0);
      pick     = $urandom_range(0, 99);
      bad_sum  = ($urandom_range(0, 3) == 0);
      abort_at = -1;
      if (pick < 4) begin
        send_item(CmdTimeout, ByteW'($urandom_range(0, 255)));
      end else begin
        if (pick < 70) begin
          len = $urandom_range(0, 8);
        end else if (pick < 92) begin
          len = $urandom_range(9, 40);
        end else begin
          // Any header length; an early timeout keeps the run bounded.
          len      = $urandom_range(0, 65535);
          abort_at = $urandom_range(0, 12);
        end
        if (abort_at < 0 && $urandom_range(0, 9) == 0) begin
          abort_at = $urandom_range(0, len + 4);
        end
        send_frame(len, bad_sum, abort_at);
      end
      if (items_sent >= next_drain) begin
        drain_results();
        next_drain = items_sent + DrainEvery;
      end
    end

    drain_results();
    calm = 1'b0;
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
